>>> sv/afs_pkg.sv
// Shared types, constants and the sample rate table for the ADTS frame sync counter.
package afs_pkg;

	// Lookahead window
	localparam int WIN_BYTES = 8;
	localparam int FILL_W    = $clog2(WIN_BYTES + 1);
	localparam int WIN_IDX_W = $clog2(WIN_BYTES);

	// Field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 13;
	localparam int IDX_W  = 4;
	localparam int RATE_W = 17;
	localparam int CNT_W  = 32;

	// Header sync pattern
	localparam logic [BYTE_W-1:0] SYNC_BYTE0 = 8'hFF;
	localparam logic [BYTE_W-1:0] SYNC1_MASK = 8'hF6;
	localparam logic [BYTE_W-1:0] SYNC1_VAL  = 8'hF0;

	// Configuration register map
	localparam int              APB_ADDR_W       = 3;
	localparam int              APB_DATA_W       = 32;
	localparam logic [APB_ADDR_W-1:0] REG_BUFFER_BYTES = 3'd0;
	localparam logic [LEN_W-1:0]      BUF_RESET        = 13'd4608;

	// Result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// One accepted stream byte
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic              is_summary;
		logic [LEN_W-1:0]  frm_bytes;
		logic [IDX_W-1:0]  rate_index;
		logic [RATE_W-1:0] rate_hz;
		logic [CNT_W-1:0]  frame_count;
	} result_t;

	// Queue fill status seen by the input stage
	typedef struct packed {
		logic [RQ_CNT_W-1:0] count;
		logic                room;
	} rq_status_t;

	// Sampling frequency index to rate in Hz; reserved codes give zero
	function automatic logic [RATE_W-1:0] rate_lookup(input logic [IDX_W-1:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			4'd12:   r = 17'd7350;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/afs_sync_core.sv
// Header search, frame length tracking and frame/summary result generation.
module afs_sync_core import afs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  in_item_t          item,
	input  logic [LEN_W-1:0]  buffer_bytes,
	output logic [1:0]        push_n,
	output result_t           push0,
	output result_t           push1
);

	// Stream state
	logic [BYTE_W-1:0] win_q [WIN_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [LEN_W-1:0]  skip_q;
	logic [LEN_W-1:0]  pend_q;
	logic [LEN_W-1:0]  since_q;
	logic              collect_q;
	logic [CNT_W-1:0]  seen_q;
	logic [RATE_W-1:0] first_rate_q;
	logic              have_first_q;

	logic [BYTE_W-1:0] win_n [WIN_BYTES];
	logic [FILL_W-1:0] fill_n;
	logic [LEN_W-1:0]  skip_n;
	logic [LEN_W-1:0]  pend_n;
	logic [LEN_W-1:0]  since_n;
	logic              collect_n;
	logic [CNT_W-1:0]  seen_n;
	logic [RATE_W-1:0] first_rate_n;
	logic              have_first_n;

	// Working signals
	logic [BYTE_W-1:0] win_w   [WIN_BYTES];
	logic [BYTE_W-1:0] shifted [WIN_BYTES];
	logic [FILL_W-1:0] wr_pos;
	logic [FILL_W-1:0] fill_w;
	logic              full;
	logic              hdr_ok;
	logic [LEN_W-1:0]  hdr_len;
	logic              short_frm;
	logic [FILL_W-1:0] shift_amt;
	logic [LEN_W-1:0]  buf_eff;
	logic [LEN_W-1:0]  target;
	logic [LEN_W-1:0]  skip_init;
	logic [LEN_W-1:0]  since_inc;
	logic [LEN_W-1:0]  skip_dec;
	logic [BYTE_W-1:0] hdr_byte2;
	logic [IDX_W-1:0]  frm_idx;
	logic [RATE_W-1:0] frm_rate;
	logic              frm_v;
	logic [LEN_W-1:0]  frm_len;
	result_t           frm_res;
	result_t           sum_res;

	// Byte written into the window, header decode and window shift
	always_comb begin
		wr_pos = (fill_q >= FILL_W'(WIN_BYTES)) ? FILL_W'(WIN_BYTES - 1) : fill_q;
		win_w = win_q;
		win_w[wr_pos[WIN_IDX_W-1:0]] = item.data;
		fill_w = wr_pos + FILL_W'(1);
		full   = (fill_w == FILL_W'(WIN_BYTES));

		hdr_ok  = (win_w[0] == SYNC_BYTE0) && ((win_w[1] & SYNC1_MASK) == SYNC1_VAL);
		hdr_len = hdr_ok ? {win_w[3][1:0], win_w[4], win_w[5][7:5]} : '0;
		short_frm = (hdr_len != '0) && (hdr_len <= LEN_W'(WIN_BYTES));
		shift_amt = (hdr_len == '0) ? FILL_W'(1) : hdr_len[FILL_W-1:0];

		// drop shift_amt bytes from the front; the tail is refilled before use
		shifted = win_w;
		for (int i = 0; i < WIN_BYTES; i++) begin
			for (int k = 1; k < WIN_BYTES - i; k++) begin
				if (shift_amt == FILL_W'(k))
					shifted[i] = win_w[i + k];
			end
		end

		// long frame: bytes to wait for, capped by the buffer size
		buf_eff   = (buffer_bytes < LEN_W'(WIN_BYTES)) ? LEN_W'(WIN_BYTES) : buffer_bytes;
		target    = (hdr_len < buf_eff) ? hdr_len : buf_eff;
		skip_init = target - LEN_W'(WIN_BYTES);

		since_inc = since_q + LEN_W'(1);
		skip_dec  = (skip_q != '0) ? skip_q - LEN_W'(1) : '0;
	end

	// Next state and result selection
	always_comb begin
		win_n        = win_q;
		fill_n       = fill_q;
		skip_n       = skip_q;
		pend_n       = pend_q;
		since_n      = since_q;
		collect_n    = collect_q;
		seen_n       = seen_q;
		first_rate_n = first_rate_q;
		have_first_n = have_first_q;
		frm_v        = 1'b0;
		frm_len      = '0;

		if (collect_q) begin
			since_n = since_inc;
			skip_n  = skip_dec;
			if (skip_dec == '0) begin
				// decision point: report only if every byte arrived
				collect_n = 1'b0;
				fill_n    = '0;
				frm_v     = (since_inc == pend_q);
				frm_len   = pend_q;
			end
		end else begin
			win_n  = win_w;
			fill_n = fill_w;
			if (full) begin
				if (hdr_len == '0) begin
					win_n  = shifted;
					fill_n = FILL_W'(WIN_BYTES - 1);
				end else if (short_frm) begin
					frm_v   = 1'b1;
					frm_len = hdr_len;
					win_n   = shifted;
					fill_n  = FILL_W'(WIN_BYTES) - hdr_len[FILL_W-1:0];
				end else begin
					collect_n = 1'b1;
					pend_n    = hdr_len;
					since_n   = LEN_W'(WIN_BYTES);
					skip_n    = skip_init;
					if (skip_init == '0) begin
						// buffer no larger than the window: discard at once
						collect_n = 1'b0;
						fill_n    = '0;
					end
				end
			end
		end

		hdr_byte2 = collect_q ? win_q[2] : win_w[2];
		frm_idx   = hdr_byte2[5:2];
		frm_rate  = rate_lookup(frm_idx);

		if (frm_v) begin
			if (seen_q != '1)
				seen_n = seen_q + CNT_W'(1);
			if (!have_first_q) begin
				have_first_n = 1'b1;
				first_rate_n = frm_rate;
			end
		end

		frm_res.is_summary   = 1'b0;
		frm_res.frm_bytes    = frm_len;
		frm_res.rate_index   = frm_idx;
		frm_res.rate_hz      = frm_rate;
		frm_res.frame_count  = seen_n;

		sum_res.is_summary   = 1'b1;
		sum_res.frm_bytes    = '0;
		sum_res.rate_index   = '0;
		sum_res.rate_hz      = first_rate_n;
		sum_res.frame_count  = seen_n;

		// frame result goes first, summary after it
		push0  = frm_v ? frm_res : sum_res;
		push1  = sum_res;
		push_n = '0;
		if (go)
			push_n = {1'b0, frm_v} + {1'b0, item.eos};

		// end of stream: back to the reset state
		if (item.eos) begin
			for (int i = 0; i < WIN_BYTES; i++)
				win_n[i] = '0;
			fill_n       = '0;
			skip_n       = '0;
			pend_n       = '0;
			since_n      = '0;
			collect_n    = 1'b0;
			seen_n       = '0;
			first_rate_n = '0;
			have_first_n = 1'b0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_BYTES; i++)
				win_q[i] <= '0;
			fill_q       <= '0;
			skip_q       <= '0;
			pend_q       <= '0;
			since_q      <= '0;
			collect_q    <= 1'b0;
			seen_q       <= '0;
			first_rate_q <= '0;
			have_first_q <= 1'b0;
		end else if (go) begin
			win_q        <= win_n;
			fill_q       <= fill_n;
			skip_q       <= skip_n;
			pend_q       <= pend_n;
			since_q      <= since_n;
			collect_q    <= collect_n;
			seen_q       <= seen_n;
			first_rate_q <= first_rate_n;
			have_first_q <= have_first_n;
		end
	end

endmodule

>>> sv/afs_result_queue.sv
// Small result queue taking up to two results per cycle and giving out one per cycle while pop_ready is high.
module afs_result_queue import afs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    push0,
	input  result_t    push1,
	input  logic       pop_ready,
	output logic       out_valid,
	output result_t    out_res,
	output rq_status_t status
);

	result_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_q;
	logic [RQ_PTR_W-1:0] rd_q;
	logic [RQ_CNT_W-1:0] count_q;
	logic [RQ_PTR_W-1:0] wr_next;
	logic                pop;

	assign out_valid    = (count_q != '0);
	assign out_res      = mem_q[rd_q];
	assign pop          = out_valid && pop_ready;
	assign wr_next      = wr_q + RQ_PTR_W'(1);
	assign status.count = count_q;
	assign status.room  = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= push0;
		if (push_n == 2'd2)
			mem_q[wr_next] <= push1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RQ_PTR_W'(push_n);
			if (pop)
				rd_q <= rd_q + RQ_PTR_W'(1);
			count_q <= count_q + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
		end
	end

endmodule

>>> sv/adts_frame_sync_counter_core.sv
// Top level of the ADTS frame sync counter: ports, register, input stage and checks.
//
//  channel   direction  request                      fields
//  s_*       in         one stream byte              tdata: stream_byte, tlast: end_of_stream
//  m_*       out        one frame or summary result  tuser: is_summary, tdata: rest
//  APB       in         register write/read          buffer_bytes at address 0
//
// One byte is taken per cycle while the queue has room: the byte sits in an input
// register, the search and counter logic updates the state and writes its results
// into a four-entry result queue. The input stalls only while the queue holds more
// than two results (an item can add two), so a stalled output side fills the queue
// and then holds s_tready low.
// Reset clears all stream state and sets buffer_bytes to 4608.
module adts_frame_sync_counter_core import afs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// stream in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] stream_byte
	input  logic                  s_tlast,   // end_of_stream
	// results out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,   // [12:0] frame length, [16:13] rate_index,
	                                         // [33:17] rate_hz, [65:34] frame_count
	output logic [0:0]            m_tuser,   // [0] is_summary
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [LEN_W-1:0] buf_bytes_q;
	in_item_t         item_s1;
	logic             valid_s1;
	logic             go;
	logic [1:0]       push_n;
	result_t          push0;
	result_t          push1;
	result_t          out_res;
	rq_status_t       rq_stat;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_BUFFER_BYTES) ? APB_DATA_W'(buf_bytes_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes_q <= BUF_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_BUFFER_BYTES) begin
			buf_bytes_q <= pwdata[LEN_W-1:0];
		end
	end

	// Input register
	assign go       = valid_s1 && rq_stat.room;
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data <= s_tdata;
			item_s1.eos  <= s_tlast;
		end
	end

	afs_sync_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.item         (item_s1),
		.buffer_bytes (buf_bytes_q),
		.push_n       (push_n),
		.push0        (push0),
		.push1        (push1)
	);

	afs_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (push0),
		.push1     (push1),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.status    (rq_stat)
	);

	// Output packing
	assign m_tuser = out_res.is_summary;
	assign m_tdata = {6'b0, out_res.frame_count, out_res.rate_hz,
		out_res.rate_index, out_res.frm_bytes};

	// Checks
	a_eos_gives_summary: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.eos |=> m_tvalid)
		else $error("no result queued after end of stream");

	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[12:0] == 13'd0 && m_tdata[16:13] == 4'd0)
		else $error("summary carries frame fields");

	a_frame_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[12:0] != 13'd0)
		else $error("frame result with zero length");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_stat.count <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue overfilled");

endmodule
